// ----- hw/rtl/tddr_pkg.sv -----
package tddr_pkg;

  // automaton limits
  localparam int MAX_STATES  = 64;
  localparam int MAX_SYMBOLS = 32;

  localparam int ROW_W   = $clog2(MAX_STATES);
  localparam int TADDR_W = $clog2(MAX_STATES * MAX_SYMBOLS);

  // fixed field widths
  localparam int STATE_W = 7;
  localparam int TSYM_W  = 5;
  localparam int CHAR_W  = 8;
  localparam int ASIZE_W = 6;
  localparam int SCNT_W  = 7;
  localparam int CNT_W   = 16;
  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [CHAR_W-1:0]  SYM_BASE    = 8'd97;  // 'a'
  localparam logic [STATE_W-1:0] START_STATE = 7'd1;
  localparam logic [CNT_W-1:0]   COUNT_MAX   = 16'hFFFF;

  localparam logic [ASIZE_W-1:0] ASIZE_RESET = 6'd26;
  localparam logic [SCNT_W-1:0]  SCNT_RESET  = 7'd64;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STATE_COUNT   = 1'b1;

  typedef enum logic [1:0] {
    K_TABLE = 2'd0,
    K_MARK  = 2'd1,
    K_CHAR  = 2'd2,
    K_EOS   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    V_ACCEPT = 2'd0,
    V_DEAD   = 2'd1,
    V_END    = 2'd2,
    V_BAD    = 2'd3
  } verdict_t;

  typedef struct packed {
    logic               en;
    logic [TADDR_W-1:0] addr;
    logic [STATE_W-1:0] data;
  } trans_wr_t;

  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] addr;
    logic             value;
  } mark_wr_t;

  // row-major address of (state, symbol); state numbered from 1
  function automatic logic [TADDR_W-1:0] table_addr(input logic [STATE_W-1:0] st,
                                                    input logic [CHAR_W-1:0] sym);
    logic [ROW_W-1:0] row;
    row = ROW_W'(st - START_STATE);
    return TADDR_W'(row) * TADDR_W'(MAX_SYMBOLS) + TADDR_W'(sym);
  endfunction

endpackage

// ----- hw/rtl/tddr_trans_mem.sv -----
module tddr_trans_mem import tddr_pkg::*; (
  input  logic               clk,
  input  trans_wr_t          wr,
  input  logic               rd_en,
  input  logic [TADDR_W-1:0] rd_addr,
  output logic [STATE_W-1:0] rd_data
);

  logic [STATE_W-1:0] mem [MAX_STATES * MAX_SYMBOLS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/tddr_mark_mem.sv -----
module tddr_mark_mem import tddr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  mark_wr_t         wr,
  input  logic             rd_en,
  input  logic [ROW_W-1:0] rd_addr,
  output logic             rd_final
);

  logic                  marks [MAX_STATES];
  logic [MAX_STATES-1:0] written;
  logic                  mark_q;
  logic                  written_q;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      marks[wr.addr] <= wr.value;
    end
    if (rd_en) begin
      mark_q <= marks[rd_addr];
    end
  end

  // an unwritten mark reads as not final
  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      written_q <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        written_q <= written[rd_addr];
      end
    end
  end

  assign rd_final = mark_q & written_q;

endmodule

// ----- hw/rtl/table_driven_dfa_recognizer_unit.sv -----
// channel  direction  handshake           word
// cfg      in         cfg_write           cfg_index, cfg_data
// in       in         in_valid/in_stall   kind, table_state, table_symbol,
//                                          table_target, final_value, character
// out      out        out_valid/out_stall verdict, consumed
//
// Table and mark writes go to memory as their word is taken. A character or
// end-of-string word holds off the next word until the transition table read
// addressed by the current state has landed, as the next character needs that
// state. The final mark is read after that, overlapped with the next word.
// Reset is immediate: no clearing pass; final marks use per-entry valid bits.
// A full, stalled output register holds the last stage and then the input.
module table_driven_dfa_recognizer_unit import tddr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,

  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           kind,
  input  logic [STATE_W-1:0]   table_state,
  input  logic [TSYM_W-1:0]    table_symbol,
  input  logic [STATE_W-1:0]   table_target,
  input  logic                 final_value,
  input  logic [CHAR_W-1:0]    character,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           verdict,
  output logic [CNT_W-1:0]     consumed
);

  // configuration
  logic [ASIZE_W-1:0] alphabet_size;
  logic [SCNT_W-1:0]  state_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_size <= ASIZE_RESET;
      state_count   <= SCNT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ALPHABET_SIZE: alphabet_size <= cfg_data[ASIZE_W-1:0];
        REG_STATE_COUNT:   state_count   <= cfg_data[SCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // run state
  logic [STATE_W-1:0] cur_state, cur_state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic               decided, decided_next;

  // pipeline
  logic               s1_valid, s1_eos, s1_bad;
  logic               s2_valid, s2_emit, s2_check;
  verdict_t           s2_verdict;
  logic [CNT_W-1:0]   s2_count;
  verdict_t           out_verdict;

  logic               acc;
  kind_t              in_kind;
  logic [CHAR_W-1:0]  sym8;
  logic               bad_sym;
  logic               wr_state_ok;
  trans_wr_t          tw;
  mark_wr_t           mw;
  logic               trd_en;
  logic [TADDR_W-1:0] trd_addr;
  logic [STATE_W-1:0] trans_q;
  logic               mark_final;

  logic               dead;
  logic [CNT_W-1:0]   count_inc;
  logic               s2_load, s2_emit_n, s2_check_n;
  verdict_t           s2_verdict_n;
  logic [CNT_W-1:0]   s2_count_n;
  logic               s2_out, s2_block, s2_fire;

  assign s2_out   = s2_emit || (s2_check && mark_final);
  assign s2_block = s2_valid && s2_out && out_valid && out_stall;
  assign s2_fire  = s2_valid && !s2_block;
  assign in_stall = s1_valid || s2_block;
  assign acc      = in_valid && !in_stall;

  // accept stage: writes go straight to memory, characters issue the table read
  always_comb begin
    in_kind     = kind_t'(kind);
    sym8        = character - SYM_BASE;
    bad_sym     = (character < SYM_BASE) || (32'(sym8) >= 32'(alphabet_size)) ||
                  (32'(sym8) >= MAX_SYMBOLS);
    wr_state_ok = (table_state != '0) && (32'(table_state) <= MAX_STATES);

    tw.en   = acc && (in_kind == K_TABLE) && wr_state_ok &&
              (32'(table_symbol) < MAX_SYMBOLS);
    tw.addr = table_addr(table_state, CHAR_W'(table_symbol));
    tw.data = table_target;

    mw.en    = acc && (in_kind == K_MARK) && wr_state_ok;
    mw.addr  = ROW_W'(table_state - START_STATE);
    mw.value = final_value;

    trd_en   = acc && (in_kind == K_CHAR);
    trd_addr = table_addr(cur_state, sym8);
  end

  tddr_trans_mem u_trans (
    .clk     (clk),
    .wr      (tw),
    .rd_en   (trd_en),
    .rd_addr (trd_addr),
    .rd_data (trans_q)
  );

  tddr_mark_mem u_marks (
    .clk      (clk),
    .rst      (rst),
    .wr       (mw),
    .rd_en    (s1_valid),
    .rd_addr  (ROW_W'(trans_q - START_STATE)),
    .rd_final (mark_final)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= acc && ((in_kind == K_CHAR) || (in_kind == K_EOS));
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_eos <= (in_kind == K_EOS);
      s1_bad <= bad_sym;
    end
  end

  // table data stage: step the machine, decide dead or bad at once
  always_comb begin
    dead = (trans_q == '0) || (32'(trans_q) > 32'(state_count)) ||
           (32'(trans_q) > MAX_STATES);
    count_inc = (count == COUNT_MAX) ? count : count + 1'b1;

    cur_state_next = cur_state;
    count_next     = count;
    decided_next   = decided;
    s2_load        = 1'b0;
    s2_emit_n      = 1'b0;
    s2_check_n     = 1'b0;
    s2_verdict_n   = V_END;
    s2_count_n     = count;

    if (s1_valid) begin
      if (s1_eos) begin
        s2_load        = !decided;
        s2_emit_n      = 1'b1;
        cur_state_next = START_STATE;
        count_next     = '0;
        decided_next   = 1'b0;
      end else if (!decided) begin
        count_next = count_inc;
        s2_load    = 1'b1;
        s2_count_n = count_inc;
        if (s1_bad) begin
          s2_emit_n    = 1'b1;
          s2_verdict_n = V_BAD;
          decided_next = 1'b1;
        end else if (dead) begin
          s2_emit_n    = 1'b1;
          s2_verdict_n = V_DEAD;
          decided_next = 1'b1;
        end else begin
          cur_state_next = trans_q;
          s2_check_n     = 1'b1;
        end
      end
    end

    // reaching a final state accepts
    if (s2_fire && s2_check && mark_final) begin
      decided_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_state <= START_STATE;
      count     <= '0;
      decided   <= 1'b0;
    end else begin
      cur_state <= cur_state_next;
      count     <= count_next;
      decided   <= decided_next;
    end
  end

  // mark stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_load) begin
      s2_valid <= 1'b1;
    end else if (s2_fire) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_emit    <= s2_emit_n;
      s2_check   <= s2_check_n;
      s2_verdict <= s2_verdict_n;
      s2_count   <= s2_count_n;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_valid && s2_out && !(out_valid && out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && s2_out && !(out_valid && out_stall)) begin
      out_verdict <= s2_check ? V_ACCEPT : s2_verdict;
      consumed    <= s2_count;
    end
  end

  assign verdict = out_verdict;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import tddr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TABLE_DEPTH = MAX_STATES * MAX_SYMBOLS;

  typedef struct packed {
    kind_t               kind;
    logic [STATE_W-1:0]  tstate;
    logic [TSYM_W-1:0]   tsym;
    logic [STATE_W-1:0]  target;
    logic                fval;
    logic [CHAR_W-1:0]   ch;
  } word_t;

  typedef struct packed {
    verdict_t           v;
    logic [CNT_W-1:0]   n;
  } verdict_word_t;

  // Shadow automaton: tracks table, marks and the current run, and queues
  // the verdict each accepted word should produce.
  class verdict_board;
    bit [STATE_W-1:0] next_state [TABLE_DEPTH];
    bit               written [TABLE_DEPTH];
    bit               final_mark [MAX_STATES];
    int unsigned      cur;
    int unsigned      count;
    int unsigned      asize;
    int unsigned      scount;
    bit               decided;
    verdict_word_t    pending [$];
    int unsigned      errors;

    function new();
      asize = ASIZE_RESET;
      scount = SCNT_RESET;
      cur = START_STATE;
      count = 0;
      decided = 1'b0;
      errors = 0;
    endfunction

    function int unsigned eff_symbols();
      return (asize < MAX_SYMBOLS) ? asize : MAX_SYMBOLS;
    endfunction

    function int unsigned eff_states();
      return (scount < MAX_STATES) ? scount : MAX_STATES;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == REG_ALPHABET_SIZE) asize = data[ASIZE_W-1:0];
      else scount = data[SCNT_W-1:0];
    endfunction

    function void conclude(verdict_t v);
      pending.push_back('{v, CNT_W'(count)});
      decided = 1'b1;
    endfunction

    function void note_word(word_t w);
      int unsigned st;
      int unsigned c;
      int unsigned idx;
      int unsigned nxt;
      st = w.tstate;
      c = w.ch;
      case (w.kind)
        K_TABLE: begin
          if (st >= 1 && st <= MAX_STATES) begin
            idx = (st - 1) * MAX_SYMBOLS + w.tsym;
            next_state[idx] = w.target;
            written[idx] = 1'b1;
          end
        end
        K_MARK: begin
          if (st >= 1 && st <= MAX_STATES) final_mark[st - 1] = w.fval;
        end
        K_EOS: begin
          if (!decided) conclude(V_END);
          cur = START_STATE;
          count = 0;
          decided = 1'b0;
        end
        default: begin
          if (!decided) begin
            if (count < COUNT_MAX) count++;
            if (c < SYM_BASE || c - SYM_BASE >= eff_symbols()) begin
              conclude(V_BAD);
            end else begin
              nxt = next_state[(cur - 1) * MAX_SYMBOLS + (c - SYM_BASE)];
              if (nxt == 0 || nxt > eff_states()) begin
                conclude(V_DEAD);
              end else begin
                cur = nxt;
                if (final_mark[nxt - 1]) conclude(V_ACCEPT);
              end
            end
          end
        end
      endcase
    endfunction

    function void check_verdict(logic [1:0] v, logic [CNT_W-1:0] n);
      verdict_word_t e;
      if (pending.size() == 0) begin
        $error("result with none expected: verdict %0d consumed %0d", v, n);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (v !== e.v) begin
        $error("verdict: expected %0d, actual %0d", e.v, v);
        errors++;
      end
      if (n !== e.n) begin
        $error("consumed: expected %0d, actual %0d", e.n, n);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           kind = '0;
  logic [STATE_W-1:0]   table_state = '0;
  logic [TSYM_W-1:0]    table_symbol = '0;
  logic [STATE_W-1:0]   table_target = '0;
  logic                 final_value = 1'b0;
  logic [CHAR_W-1:0]    character = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           verdict;
  logic [CNT_W-1:0]     consumed;

  verdict_board sb = new();
  int unsigned  tx_gap_pct = 0;
  int unsigned  rx_stall_pct = 0;
  int unsigned  long_hold = 0;
  int unsigned  cycle_count = 0;

  table_driven_dfa_recognizer_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .table_state  (table_state),
    .table_symbol (table_symbol),
    .table_target (table_target),
    .final_value  (final_value),
    .character    (character),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .verdict      (verdict),
    .consumed     (consumed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_verdict(verdict, consumed);
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold != 0) begin
        out_stall <= 1'b1;
        repeat (long_hold) @(posedge clk);
        long_hold = 0;
        out_stall <= 1'b0;
      end else if (rx_stall_pct != 0 && $urandom_range(0, 399) < rx_stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic word_t make_word(kind_t k, int unsigned st, int unsigned sym,
                                      int unsigned tgt, int unsigned fv,
                                      int unsigned ch);
    word_t w;
    w.kind = k;
    w.tstate = STATE_W'(st);
    w.tsym = TSYM_W'(sym);
    w.target = STATE_W'(tgt);
    w.fval = fv[0];
    w.ch = CHAR_W'(ch);
    return w;
  endfunction

  function automatic int unsigned pick_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 15;
      default: return 40;
    endcase
  endfunction

  // next state for a fresh table entry: mostly live, sometimes dead or beyond
  function automatic int unsigned pick_target();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7 && sb.eff_states() > 0) return $urandom_range(1, sb.eff_states());
    if (r == 7) return 0;
    if (r == 8) return $urandom_range(0, 127);
    return $urandom_range(1, MAX_STATES);
  endfunction

  // called at a clock edge; returns at the edge where the word was taken, or after a random gap behind it
  task automatic send_word(word_t w);
    in_valid <= 1'b1;
    kind <= w.kind;
    table_state <= w.tstate;
    table_symbol <= w.tsym;
    table_target <= w.target;
    final_value <= w.fval;
    character <= w.ch;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_word(w);
    if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // an in-alphabet character of an undecided run whose table entry is still blank gets one written first
  task automatic send_char(int unsigned ch);
    int unsigned sym;
    int unsigned tgt;
    if (!sb.decided && ch >= SYM_BASE && ch - SYM_BASE < sb.eff_symbols()) begin
      sym = ch - SYM_BASE;
      if (!sb.written[(sb.cur - 1) * MAX_SYMBOLS + sym]) begin
        tgt = pick_target();
        send_word(make_word(K_TABLE, sb.cur, sym, tgt, $urandom, $urandom));
        if (tgt >= 1 && tgt <= MAX_STATES && $urandom_range(0, 3) == 0)
          send_word(make_word(K_MARK, tgt, $urandom, $urandom, $urandom, $urandom));
      end
    end
    send_word(make_word(K_CHAR, $urandom, $urandom, $urandom, $urandom, ch));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
    cfg_write <= 1'b0;
  endtask

  task automatic run_phase(int unsigned n_words, bit quiet);
    int unsigned r;
    for (int unsigned i = 0; i < n_words; i++) begin
      if (i % 40 == 0) begin
        tx_gap_pct = quiet ? 0 : pick_pct();
        rx_stall_pct = quiet ? 0 : pick_pct();
      end
      r = $urandom_range(0, 99);
      if (r < 5)
        send_word(make_word(K_TABLE, $urandom_range(0, 127), $urandom,
                            $urandom_range(0, 127), $urandom, $urandom));
      else if (r < 10)
        send_word(make_word(K_MARK, $urandom_range(0, 127), $urandom, $urandom,
                            $urandom, $urandom));
      else if (r < 22)
        send_word(make_word(K_EOS, $urandom, $urandom, $urandom, $urandom, $urandom));
      else if (r < 30 || sb.eff_symbols() == 0)
        send_char($urandom_range(0, 255));
      else
        send_char(SYM_BASE + $urandom_range(0, sb.eff_symbols() - 1));
    end
  endtask

  initial begin
    int unsigned phase_asize [7];
    int unsigned phase_scount [7];
    phase_asize = '{32, 1, 0, 63, 5, 26, 17};
    phase_scount = '{64, 1, 5, 127, 0, 64, 40};

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    tx_gap_pct = 15;
    rx_stall_pct = 15;
    // empty string, then symbols below and beyond the alphabet
    send_word(make_word(K_EOS, 0, 0, 0, 0, 0));
    send_word(make_word(K_CHAR, 0, 0, 0, 0, SYM_BASE - 1));
    send_word(make_word(K_CHAR, 0, 0, 0, 0, SYM_BASE));    // ignored after verdict
    send_word(make_word(K_EOS, 0, 0, 0, 0, 0));             // silent restart
    send_word(make_word(K_CHAR, 0, 0, 0, 0, SYM_BASE + 26));
    send_word(make_word(K_EOS, 0, 0, 0, 0, 0));
    // accept on entering a final state
    send_word(make_word(K_TABLE, 1, 0, 2, 0, 0));
    send_word(make_word(K_MARK, 2, 0, 0, 1, 0));
    send_word(make_word(K_CHAR, 0, 0, 0, 0, SYM_BASE));
    send_word(make_word(K_EOS, 0, 0, 0, 0, 0));
    // dead target, and a target beyond the state count
    send_word(make_word(K_TABLE, 1, 1, 0, 0, 0));
    send_word(make_word(K_CHAR, 0, 0, 0, 0, SYM_BASE + 1));
    send_word(make_word(K_EOS, 0, 0, 0, 0, 0));
    send_word(make_word(K_TABLE, 1, 2, 100, 0, 0));
    send_word(make_word(K_CHAR, 0, 0, 0, 0, SYM_BASE + 2));
    send_word(make_word(K_EOS, 0, 0, 0, 0, 0));
    // out-of-range writes must not alias onto real rows
    send_word(make_word(K_TABLE, 1, 3, 3, 0, 0));
    send_word(make_word(K_TABLE, 65, 3, 0, 0, 0));
    send_word(make_word(K_MARK, 67, 0, 0, 1, 0));
    send_word(make_word(K_TABLE, 1, 4, 64, 0, 0));
    send_word(make_word(K_TABLE, 64, 0, 5, 0, 0));
    send_word(make_word(K_TABLE, 0, 0, 0, 0, 0));
    send_word(make_word(K_MARK, 0, 0, 0, 1, 0));
    send_word(make_word(K_CHAR, 0, 0, 0, 0, SYM_BASE + 3));
    send_word(make_word(K_EOS, 0, 0, 0, 0, 0));
    send_word(make_word(K_CHAR, 0, 0, 0, 0, SYM_BASE + 4));
    send_word(make_word(K_CHAR, 0, 0, 0, 0, SYM_BASE));
    send_word(make_word(K_EOS, 0, 0, 0, 0, 0));

    for (int p = 0; p < 7; p++) begin
      write_reg(REG_ALPHABET_SIZE, {1'($urandom), ASIZE_W'(phase_asize[p])});
      write_reg(REG_STATE_COUNT, SCNT_W'(phase_scount[p]));
      run_phase(120, p == 6);
      if (p == 1) begin
        // long receiver hold-off while words keep coming, then drain fully
        tx_gap_pct = 0;
        rx_stall_pct = 0;
        long_hold = 300;
        repeat (40) send_word(make_word(K_EOS, $urandom, $urandom, $urandom,
                                        $urandom, $urandom));
        settle();
      end
    end

    settle();
    repeat (12) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
